/* rtl/lpfd_pkg.sv */
// lpfd_pkg: constants, codes and the crc-16 byte update for the frame decoder
// depends on nothing; used by the interfaces, the decoder and its checker

package lpfd_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned CRC_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [BYTE_W-1:0] START_SHORT    = 8'd2;
  localparam logic [BYTE_W-1:0] START_LONG     = 8'd3;
  localparam logic [BYTE_W-1:0] STOP_BYTE      = 8'd3;
  localparam logic [CRC_W-1:0]  CRC_POLY       = 16'h1021;
  localparam logic [LEN_W-1:0]  MAX_LONG_RESET = 16'd512;

  // register index, taken from paddr[2]
  localparam logic REG_MAX_LONG = 1'b0;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD  = 2'd0,
    KIND_ACCEPTED = 2'd1,
    KIND_BAD_STOP = 2'd2,
    KIND_CRC_ERR  = 2'd3
  } kind_e;

  typedef enum logic [7:0] {
    PH_HUNT      = 8'b0000_0001,
    PH_SHORT_LEN = 8'b0000_0010,
    PH_LONG_HI   = 8'b0000_0100,
    PH_LONG_LO   = 8'b0000_1000,
    PH_PAYLOAD   = 8'b0001_0000,
    PH_CRC_HI    = 8'b0010_0000,
    PH_CRC_LO    = 8'b0100_0000,
    PH_STOP      = 8'b1000_0000
  } phase_e;

  // crc-16 msb first, one byte
  function automatic logic [CRC_W-1:0] crc16_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

/* rtl/lpfd_if.sv */
// lpfd_rx_if and lpfd_res_if: valid/ready channels of the frame decoder
// depends on lpfd_pkg for field widths

interface lpfd_rx_if
  import lpfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfd_res_if
  import lpfd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BYTE_W-1:0] data;
  logic [LEN_W-1:0]  frame_length;

  modport source (output valid, output kind, output data, output frame_length,
                  input ready);
  modport sink   (input valid, input kind, input data, input frame_length,
                  output ready);
endinterface

/* rtl/length_prefixed_frame_decoder.sv */
// length_prefixed_frame_decoder: byte-wise frame hunter with crc-16 check
// depends on lpfd_pkg and the channel interfaces in lpfd_if.sv
//
//  channel  direction  transaction payload              handshake
//  rx_i     in         rx_byte[7:0]                     valid/ready
//  res_o    out        kind[1:0] data[7:0] frame_length valid/ready
//  apb      in         max_long_payload at 0x0          psel/penable/pwrite
//
// one byte per cycle: the frame state and the crc byte update sit between the
// state registers and a single result register; a byte is taken whenever that
// register is empty or being emptied in the same cycle
// reset is asynchronous, active low; it returns to hunting and max to 512
// a stalled result holds rx_i.ready low until that result transaction is taken

module length_prefixed_frame_decoder
  import lpfd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  lpfd_rx_if.sink            rx_i,
  lpfd_res_if.source         res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  phase_e            phase_q, phase_d;
  logic [LEN_W-1:0]  max_q;
  logic [BYTE_W-1:0] len_hi_q, len_hi_d;
  logic [LEN_W-1:0]  plen_q, plen_d;
  logic [LEN_W-1:0]  seen_q, seen_d;
  logic [CRC_W-1:0]  crc_q, crc_d;
  logic [CRC_W-1:0]  rcrc_q, rcrc_d;

  logic              out_valid_q;
  kind_e             kind_q, kind_d;
  logic [BYTE_W-1:0] data_q, data_d;
  logic [LEN_W-1:0]  flen_q, flen_d;

  logic              accept;
  logic              has_res;
  logic              load;
  logic              cfg_wr;
  logic [BYTE_W-1:0] b;
  logic [LEN_W-1:0]  long_len;

  assign b        = rx_i.rx_byte;
  assign long_len = {len_hi_q, b};

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign accept     = rx_i.valid && rx_i.ready;
  assign load       = accept && has_res;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_LONG);
  assign prdata = (paddr[2] == REG_MAX_LONG) ? {{(PDATA_W-LEN_W){1'b0}}, max_q}
                                             : '0;

  always_comb begin
    phase_d  = phase_q;
    len_hi_d = len_hi_q;
    plen_d   = plen_q;
    seen_d   = seen_q;
    crc_d    = crc_q;
    rcrc_d   = rcrc_q;
    has_res  = 1'b0;
    kind_d   = KIND_PAYLOAD;
    data_d   = '0;
    flen_d   = '0;

    case (phase_q)
      PH_HUNT: begin
        if (b == START_SHORT) begin
          phase_d = PH_SHORT_LEN;
        end else if (b == START_LONG) begin
          phase_d = PH_LONG_HI;
        end
      end
      PH_SHORT_LEN: begin
        if (b == '0) begin
          phase_d = PH_HUNT;
        end else begin
          phase_d = PH_PAYLOAD;
          plen_d  = {{(LEN_W-BYTE_W){1'b0}}, b};
          seen_d  = '0;
          crc_d   = '0;
          rcrc_d  = '0;
        end
      end
      PH_LONG_HI: begin
        len_hi_d = b;
        phase_d  = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        if ((len_hi_q != '0) && (long_len <= max_q)) begin
          phase_d = PH_PAYLOAD;
          plen_d  = long_len;
          seen_d  = '0;
          crc_d   = '0;
          rcrc_d  = '0;
        end else if (len_hi_q == START_SHORT) begin
          // high length byte rescanned as a short start
          if (b == '0) begin
            phase_d = PH_HUNT;
          end else begin
            phase_d = PH_PAYLOAD;
            plen_d  = {{(LEN_W-BYTE_W){1'b0}}, b};
            seen_d  = '0;
            crc_d   = '0;
            rcrc_d  = '0;
          end
        end else if (len_hi_q == START_LONG) begin
          len_hi_d = b;
          phase_d  = PH_LONG_LO;
        end else if (b == START_SHORT) begin
          phase_d = PH_SHORT_LEN;
        end else if (b == START_LONG) begin
          phase_d = PH_LONG_HI;
        end else begin
          phase_d = PH_HUNT;
        end
      end
      PH_PAYLOAD: begin
        crc_d   = crc16_byte(crc_q, b);
        seen_d  = LEN_W'(seen_q + 16'd1);
        if (seen_d >= plen_q) begin
          phase_d = PH_CRC_HI;
        end
        has_res = 1'b1;
        kind_d  = KIND_PAYLOAD;
        data_d  = b;
      end
      PH_CRC_HI: begin
        rcrc_d  = {b, 8'h00};
        phase_d = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rcrc_d  = rcrc_q | {8'h00, b};
        phase_d = PH_STOP;
      end
      PH_STOP: begin
        phase_d = PH_HUNT;
        has_res = 1'b1;
        flen_d  = plen_q;
        if (b != STOP_BYTE) begin
          kind_d = KIND_BAD_STOP;
        end else if (rcrc_q != crc_q) begin
          kind_d = KIND_CRC_ERR;
        end else begin
          kind_d = KIND_ACCEPTED;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HUNT;
      max_q       <= MAX_LONG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        phase_q <= phase_d;
      end
      if (cfg_wr) begin
        max_q <= pwdata[LEN_W-1:0];
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // frame fields are always written before they are read
  always_ff @(posedge clk_i) begin
    if (accept) begin
      len_hi_q <= len_hi_d;
      plen_q   <= plen_d;
      seen_q   <= seen_d;
      crc_q    <= crc_d;
      rcrc_q   <= rcrc_d;
    end
    if (load) begin
      kind_q <= kind_d;
      data_q <= data_d;
      flen_q <= flen_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.kind         = kind_q;
  assign res_o.data         = data_q;
  assign res_o.frame_length = flen_q;

endmodule

/* rtl/lpfd_checker.sv */
// lpfd_checker: port-level assertions for length_prefixed_frame_decoder
// depends on lpfd_pkg; bound to the top level at the end of this file

module lpfd_checker
  import lpfd_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              res_valid_i,
  input logic              res_ready_i,
  input logic [KIND_W-1:0] res_kind_i,
  input logic [BYTE_W-1:0] res_data_i,
  input logic [LEN_W-1:0]  res_frame_length_i,
  input logic              pready_i
);

  // a stalled result transaction keeps its payload
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(res_kind_i)
      && $stable(res_data_i) && $stable(res_frame_length_i))
    else $error("result changed while stalled");

  a_payload_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i == KIND_PAYLOAD) |-> res_frame_length_i == '0)
    else $error("payload byte carries a frame length");

  // a verdict never carries data, and a frame is never empty
  a_verdict_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (res_kind_i != KIND_PAYLOAD)
      |-> (res_data_i == '0) && (res_frame_length_i != '0))
    else $error("bad verdict fields");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_i)
    else $error("pready dropped");

endmodule

bind length_prefixed_frame_decoder lpfd_checker u_lpfd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_kind_i         (res_o.kind),
  .res_data_i         (res_o.data),
  .res_frame_length_i (res_o.frame_length),
  .pready_i           (pready)
);

/* tb/length_prefixed_frame_decoder_tb.sv */
`timescale 1ns / 100ps
// length_prefixed_frame_decoder_tb: self-checking bench for the frame decoder,
// with an in-bench decoder model, a byte driver, a result monitor and apb setup
// depends on lpfd_pkg, lpfd_if.sv and the length_prefixed_frame_decoder rtl

module length_prefixed_frame_decoder_tb;
  import lpfd_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES   = 200;
  localparam int unsigned PRINT_LIMIT   = 40;

  localparam logic [ADDR_W-1:0] ADDR_MAX_LONG = {REG_MAX_LONG, 2'b00};
  localparam logic [ADDR_W-1:0] ADDR_SPARE    = 3'b100;

  typedef enum int {
    FRAME_GOOD,
    FRAME_BAD_STOP,
    FRAME_BAD_CRC,
    FRAME_BAD_BOTH
  } frame_fault_e;

  typedef struct {
    kind_e             kind;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  flen;
  } frame_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [ADDR_W-1:0]  paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  lpfd_rx_if  rx_if ();
  lpfd_res_if res_if ();

  length_prefixed_frame_decoder dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .rx_i    (rx_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  logic [BYTE_W-1:0] link_bytes[$];
  frame_result_t     frame_results[$];
  frame_result_t     want;
  int unsigned       n_pushed       = 0;
  int unsigned       errors         = 0;
  int unsigned       cycle_count    = 0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       recv_hold_left = 0;

  // decoder model state
  logic [LEN_W-1:0]  max_long   = MAX_LONG_RESET;
  phase_e            dec_phase  = PH_HUNT;
  logic [BYTE_W-1:0] dec_len_hi = '0;
  logic [LEN_W-1:0]  dec_len    = '0;
  logic [LEN_W-1:0]  dec_seen   = '0;
  logic [CRC_W-1:0]  dec_crc    = '0;
  logic [CRC_W-1:0]  dec_rx_crc = '0;

  task automatic flag_mismatch(input string what);
    if (errors < PRINT_LIMIT) begin
      $display("mismatch at cycle %0d: %s", cycle_count, what);
    end
    errors++;
  endtask

  function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] acc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) begin
      r = r[CRC_W-1] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  function automatic phase_e hunt_next(input logic [BYTE_W-1:0] b);
    if (b == START_SHORT) return PH_SHORT_LEN;
    if (b == START_LONG) return PH_LONG_HI;
    return PH_HUNT;
  endfunction

  task automatic open_payload(input logic [LEN_W-1:0] len);
    dec_len    = len;
    dec_seen   = '0;
    dec_crc    = '0;
    dec_rx_crc = '0;
    dec_phase  = PH_PAYLOAD;
  endtask

  task automatic take_short_len(input logic [BYTE_W-1:0] b);
    if (b == 8'h00) begin
      dec_phase = PH_HUNT;
    end else begin
      open_payload({8'h00, b});
    end
  endtask

  task automatic decode_byte(input logic [BYTE_W-1:0] b);
    logic [LEN_W-1:0] len;
    frame_result_t    r;
    case (dec_phase)
      PH_SHORT_LEN: take_short_len(b);
      PH_LONG_HI: begin
        dec_len_hi = b;
        dec_phase  = PH_LONG_LO;
      end
      PH_LONG_LO: begin
        len = {dec_len_hi, b};
        if (len > 16'd255 && len <= max_long) begin
          open_payload(len);
        end else if (dec_len_hi == START_SHORT) begin
          // rejected long header: high byte reread as a short start
          take_short_len(b);
        end else if (dec_len_hi == START_LONG) begin
          dec_len_hi = b;
          dec_phase  = PH_LONG_LO;
        end else begin
          dec_phase = hunt_next(b);
        end
      end
      PH_PAYLOAD: begin
        dec_crc  = crc_step(dec_crc, b);
        dec_seen = dec_seen + 1'b1;
        if (dec_seen >= dec_len) dec_phase = PH_CRC_HI;
        r.kind = KIND_PAYLOAD;
        r.data = b;
        r.flen = '0;
        frame_results.insert(frame_results.size(), r);
      end
      PH_CRC_HI: begin
        dec_rx_crc = {b, 8'h00};
        dec_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        dec_rx_crc[7:0] = b;
        dec_phase       = PH_STOP;
      end
      PH_STOP: begin
        dec_phase = PH_HUNT;
        // stop byte wins over the crc check
        if (b != STOP_BYTE) begin
          r.kind = KIND_BAD_STOP;
        end else if (dec_rx_crc != dec_crc) begin
          r.kind = KIND_CRC_ERR;
        end else begin
          r.kind = KIND_ACCEPTED;
        end
        r.data = '0;
        r.flen = dec_len;
        frame_results.insert(frame_results.size(), r);
      end
      default: dec_phase = hunt_next(b);
    endcase
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rx_if.valid && rx_if.ready) decode_byte(rx_if.rx_byte);
      if (!rx_if.valid || rx_if.ready) begin
        if (link_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          rx_if.valid   <= 1'b1;
          rx_if.rx_byte <= link_bytes.pop_front();
        end else begin
          rx_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready) begin
        if (frame_results.size() == 0) begin
          flag_mismatch($sformatf("unexpected result kind %0d data %02h len %0d",
                                  res_if.kind, res_if.data, res_if.frame_length));
        end else begin
          want = frame_results.pop_front();
          if (res_if.kind !== want.kind) begin
            flag_mismatch($sformatf("kind %0d, expected %0d", res_if.kind, want.kind));
          end
          if (res_if.data !== want.data) begin
            flag_mismatch($sformatf("data %02h, expected %02h", res_if.data, want.data));
          end
          if (res_if.frame_length !== want.flen) begin
            flag_mismatch($sformatf("frame_length %0d, expected %0d",
                                    res_if.frame_length, want.flen));
          end
        end
      end
      res_if.ready <= (recv_hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // long receiver hold-off
  always @(posedge clk_i) begin
    if (recv_hold_left != 0) recv_hold_left <= recv_hold_left - 1;
  end

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic apb_cycle(input logic wr, input logic [ADDR_W-1:0] a,
                           input logic [PDATA_W-1:0] d, output logic [PDATA_W-1:0] q);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= a;
    pwdata  <= d;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    q = prdata;
    if (wr && a == ADDR_MAX_LONG) max_long <= d[LEN_W-1:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write one address, then read the length register back
  task automatic set_register(input logic [ADDR_W-1:0] a, input logic [PDATA_W-1:0] d);
    logic [PDATA_W-1:0] q;
    apb_cycle(1'b1, a, d, q);
    apb_cycle(1'b0, ADDR_MAX_LONG, '0, q);
    if (q !== {{(PDATA_W-LEN_W){1'b0}}, max_long}) begin
      flag_mismatch($sformatf("max_long_payload reads %08h, expected %04h", q, max_long));
    end
    @(negedge clk_i);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] b);
    link_bytes.insert(link_bytes.size(), b);
    n_pushed++;
  endtask

  function automatic frame_fault_e pick_fault();
    int unsigned r;
    r = $urandom_range(19);
    if (r < 2) return FRAME_BAD_STOP;
    if (r < 4) return FRAME_BAD_CRC;
    if (r < 5) return FRAME_BAD_BOTH;
    return FRAME_GOOD;
  endfunction

  // payload, crc and stop byte of a frame whose header is already queued
  task automatic push_body(input logic [LEN_W-1:0] len, input frame_fault_e fault);
    logic [CRC_W-1:0]  crc;
    logic [BYTE_W-1:0] b;
    crc = '0;
    for (int i = 0; i < len; i++) begin
      b   = 8'($urandom_range(255));
      crc = crc_step(crc, b);
      push_byte(b);
    end
    if (fault == FRAME_BAD_CRC || fault == FRAME_BAD_BOTH) begin
      crc = crc ^ 16'($urandom_range(1, 65535));
    end
    push_byte(crc[15:8]);
    push_byte(crc[7:0]);
    if (fault == FRAME_BAD_STOP || fault == FRAME_BAD_BOTH) begin
      b = 8'($urandom_range(254));
      if (b >= STOP_BYTE) b = b + 1'b1;
      push_byte(b);
    end else begin
      push_byte(STOP_BYTE);
    end
  endtask

  task automatic push_frame(input logic is_long, input logic [LEN_W-1:0] len,
                            input frame_fault_e fault);
    if (is_long) begin
      push_byte(START_LONG);
      push_byte(len[15:8]);
      push_byte(len[7:0]);
    end else begin
      push_byte(START_SHORT);
      push_byte(len[7:0]);
    end
    push_body(len, fault);
  endtask

  // a header the decoder must reject, picked so that it never opens a huge payload
  task automatic push_broken_header(input logic [LEN_W-1:0] gen_max);
    int unsigned       k;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] lo;
    logic [LEN_W-1:0]  len;
    k = $urandom_range(4);
    if (k == 0) begin
      push_byte(START_SHORT);
      push_byte(8'h00);
    end else begin
      if (k == 2) begin
        hi = START_SHORT;
        lo = 8'($urandom_range(8));
      end else if (k == 3) begin
        hi = START_LONG;
        lo = 8'h00;
      end else if (k == 4) begin
        hi = 8'($urandom_range(4, 255));
        lo = 8'($urandom_range(255));
      end else begin
        hi = 8'h00;
        lo = 8'($urandom_range(255));
      end
      len = {hi, lo};
      if (len > 16'd255 && len <= gen_max) hi = 8'h00;
      push_byte(START_LONG);
      push_byte(hi);
      push_byte(lo);
      if (hi == START_SHORT && lo != 8'h00) begin
        push_body({8'h00, lo}, pick_fault());
      end else if (hi == START_LONG) begin
        push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic gen_traffic(input logic [LEN_W-1:0] gen_max, input int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = n_pushed;
    while (n_pushed - start < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        push_frame(1'b0, ($urandom_range(39) == 0) ? 16'd255 : 16'($urandom_range(1, 12)),
                   pick_fault());
      end else if (pick < 88) begin
        push_broken_header(gen_max);
      end else begin
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic drain();
    while (link_bytes.size() != 0 || rx_if.valid || frame_results.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] max_v, input int unsigned s_pct,
                           input int unsigned r_pct, input int unsigned n);
    set_register(ADDR_MAX_LONG, {{(PDATA_W-LEN_W){1'b0}}, max_v});
    send_idle_pct  = s_pct;
    recv_stall_pct = r_pct;
    gen_traffic(max_v, n);
    drain();
  endtask

  initial begin
    rst_ni        = 1'b0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    res_if.ready  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed frames against the reset value of the length register
    push_byte(8'hFF);
    push_byte(8'h00);
    push_byte(START_SHORT);
    push_byte(8'h00);
    push_frame(1'b0, 16'd1, FRAME_GOOD);
    push_frame(1'b0, 16'd1, FRAME_BAD_BOTH);
    push_frame(1'b0, 16'd1, FRAME_BAD_CRC);
    // long length too short, neither length byte is a start
    push_byte(START_LONG);
    push_byte(8'h00);
    push_byte(8'h05);
    // long length too big with a short start as high byte
    push_byte(START_LONG);
    push_byte(START_SHORT);
    push_byte(8'h01);
    push_body(16'd1, FRAME_GOOD);
    // long length too big with a long start as high byte
    push_byte(START_LONG);
    push_byte(START_LONG);
    push_byte(8'hFF);
    push_byte(8'h00);
    // one long frame just above the short range
    push_frame(1'b1, 16'($urandom_range(256, 270)), pick_fault());
    drain();

    run_phase(16'd512, 0, 0, 70);
    run_phase(16'd256, 48, 0, 70);
    run_phase(16'hFFFF, 0, 48, 70);
    set_register(ADDR_SPARE, $urandom);
    run_phase(16'd255, 17, 17, 70);
    run_phase(16'd0, 48, 48, 70);

    // receiver holds off while back-to-back frames fill the decoder
    set_register(ADDR_MAX_LONG, {{(PDATA_W-LEN_W){1'b0}}, 16'd300});
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    recv_hold_left = HOLD_CYCLES;
    repeat (3) push_frame(1'b0, 16'd10, FRAME_GOOD);
    drain();
    recv_stall_pct = 48;
    gen_traffic(16'd300, 70);
    drain();

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
